### hw/rtl/cufc_pkg.sv
// ----------------------------------------------------------------------------
// cufc_pkg
// shared codes, command type and crc-8 (poly 0xd5, msb first) for the
// camera uart frame codec
// ----------------------------------------------------------------------------
`default_nettype none

package cufc_pkg;

  localparam logic [7:0] HdrByte = 8'hCC;
  localparam logic [7:0] CrcPoly = 8'hD5;

  // input action codes
  localparam logic [1:0] ActTx    = 2'd0;
  localparam logic [1:0] ActRx    = 2'd1;
  localparam logic [1:0] ActAbort = 2'd2;

  // result kind codes
  localparam logic [1:0] KindTx      = 2'd0;
  localparam logic [1:0] KindPayload = 2'd1;
  localparam logic [1:0] KindGood    = 2'd2;
  localparam logic [1:0] KindBad     = 2'd3;

  // queue between front and back
  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);

  typedef enum logic [1:0] {
    OP_TX,
    OP_RX,
    OP_ABORT
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
    logic       first;
    logic       last;
  } cmd_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

  function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

  // crc after folding the header into a zero seed
  localparam logic [7:0] HdrCrc = crc_fold(8'h00, HdrByte);

endpackage

`default_nettype wire

### hw/rtl/cufc_front.sv
// ----------------------------------------------------------------------------
// cufc_front
// accepts input items and classifies them into queue commands
// ----------------------------------------------------------------------------
`default_nettype none

module cufc_front
  import cufc_pkg::*;
(
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,
  input  wire logic [2:0] s_axis_tuser_i,
  input  wire logic       s_axis_tlast_i,
  input  wire logic       q_full_i,
  output logic            push_o,
  output cmd_t            cmd_o
);

  logic keep;

  assign s_axis_tready_o = !q_full_i;

  always_comb begin
    keep        = 1'b1;
    cmd_o.op    = OP_TX;
    cmd_o.data  = s_axis_tdata_i;
    cmd_o.first = s_axis_tuser_i[2];
    cmd_o.last  = s_axis_tlast_i;
    unique case (s_axis_tuser_i[1:0])
      ActTx:    cmd_o.op = OP_TX;
      ActRx:    cmd_o.op = OP_RX;
      ActAbort: cmd_o.op = OP_ABORT;
      default:  keep = 1'b0;  // unused action, dropped
    endcase
  end

  assign push_o = s_axis_tvalid_i && !q_full_i && keep;

endmodule

`default_nettype wire

### hw/rtl/cufc_queue.sv
// ----------------------------------------------------------------------------
// cufc_queue
// small command queue between front and back ends
// ----------------------------------------------------------------------------
`default_nettype none

module cufc_queue
  import cufc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  input  wire logic pop_i,
  output logic      full_o,
  output head_t     head_o
);

  cmd_t           mem_q [QDepth];
  logic [QAw-1:0] wr_ptr_q, wr_ptr_d;
  logic [QAw-1:0] rd_ptr_q, rd_ptr_d;
  logic [QAw:0]   count_q, count_d;
  logic           do_pop;

  assign full_o       = (count_q == QAw'(0) + (QAw+1)'(QDepth));
  assign head_o.valid = (count_q != '0);
  assign head_o.cmd   = mem_q[rd_ptr_q];
  assign do_pop       = pop_i && head_o.valid;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + QAw'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + QAw'(1) : rd_ptr_q;
    count_d  = count_q + (QAw+1)'(push_i) - (QAw+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/cufc_back.sv
// ----------------------------------------------------------------------------
// cufc_back
// executes queued commands: crc state, framing steps, output register
// ----------------------------------------------------------------------------
`default_nettype none

module cufc_back
  import cufc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire head_t      head_i,
  output logic            pop_o,
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,
  output logic [1:0]      m_axis_tuser_o,
  output logic            m_axis_tlast_o
);

  // transmit step within one item
  localparam logic [1:0] PhStart = 2'd0;
  localparam logic [1:0] PhByte  = 2'd1;
  localparam logic [1:0] PhCrc   = 2'd2;

  logic [1:0] ph_q, ph_d;
  logic [7:0] tx_crc_q, tx_crc_d;
  logic [7:0] rx_crc_q, rx_crc_d;
  logic       in_frame_q, in_frame_d;

  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic [1:0] out_kind_q;
  logic       out_last_q;

  logic       can_emit;
  logic       emit;
  logic [1:0] res_kind;
  logic [7:0] res_byte;
  logic       res_last;
  cmd_t       cmd;

  assign cmd      = head_i.cmd;
  assign can_emit = !out_valid_q || m_axis_tready_i;

  always_comb begin
    pop_o      = 1'b0;
    emit       = 1'b0;
    res_kind   = KindTx;
    res_byte   = 8'h00;
    res_last   = 1'b0;
    ph_d       = ph_q;
    tx_crc_d   = tx_crc_q;
    rx_crc_d   = rx_crc_q;
    in_frame_d = in_frame_q;
    if (head_i.valid) begin
      unique case (cmd.op)
        OP_TX: begin
          if (can_emit) begin
            emit = 1'b1;
            if (ph_q == PhStart && cmd.first) begin
              res_byte = HdrByte;
              tx_crc_d = HdrCrc;
              ph_d     = PhByte;
            end else if (ph_q == PhCrc) begin
              res_byte = tx_crc_q;
              res_last = 1'b1;
              pop_o    = 1'b1;
              ph_d     = PhStart;
            end else begin
              res_byte = cmd.data;
              tx_crc_d = crc_fold(tx_crc_q, cmd.data);
              if (cmd.last) begin
                ph_d = PhCrc;
              end else begin
                res_last = 1'b1;
                pop_o    = 1'b1;
                ph_d     = PhStart;
              end
            end
          end
        end
        OP_RX: begin
          if (!in_frame_q) begin
            // hunting: only the header matters, nothing is emitted
            pop_o = 1'b1;
            if (cmd.data == HdrByte) begin
              rx_crc_d   = HdrCrc;
              in_frame_d = 1'b1;
            end
          end else if (can_emit) begin
            emit     = 1'b1;
            res_last = 1'b1;
            pop_o    = 1'b1;
            if (cmd.data == rx_crc_q) begin
              res_kind   = KindGood;
              in_frame_d = 1'b0;
              rx_crc_d   = 8'h00;
            end else begin
              res_kind = KindPayload;
              res_byte = cmd.data;
              rx_crc_d = crc_fold(rx_crc_q, cmd.data);
            end
          end
        end
        OP_ABORT: begin
          if (!in_frame_q) begin
            pop_o = 1'b1;
          end else if (can_emit) begin
            emit       = 1'b1;
            res_kind   = KindBad;
            res_last   = 1'b1;
            pop_o      = 1'b1;
            in_frame_d = 1'b0;
            rx_crc_d   = 8'h00;
          end
        end
        default: pop_o = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q        <= PhStart;
      tx_crc_q    <= 8'h00;
      rx_crc_q    <= 8'h00;
      in_frame_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      ph_q       <= ph_d;
      tx_crc_q   <= tx_crc_d;
      rx_crc_q   <= rx_crc_d;
      in_frame_q <= in_frame_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= res_byte;
      out_kind_q <= res_kind;
      out_last_q <= res_last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_byte_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

  // a transmit item in progress keeps its command at the queue head
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q != PhStart) |-> (head_i.valid && head_i.cmd.op == OP_TX))
    else $error("transmit step pending without its command");

  // receive-side results only come out of an open frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && res_kind != KindTx) |-> in_frame_q)
    else $error("receive result while hunting");

  // a frame end returns to hunting with a cleared crc
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && (res_kind == KindGood || res_kind == KindBad))
      |=> (!in_frame_q && rx_crc_q == 8'h00))
    else $error("frame end left receive state open");

endmodule

`default_nettype wire

### hw/rtl/camera_uart_frame_codec.sv
// ----------------------------------------------------------------------------
// camera_uart_frame_codec
// byte framer / deframer for a camera control link with crc-8 dvb-s2 check
// ----------------------------------------------------------------------------
//
//   channel   dir  tdata           tuser                          tlast
//   s_axis    in   data_byte[7:0]  action[1:0], first_of_frame[2]  last_of_frame
//   m_axis    out  out_byte[7:0]   kind[1:0]                       final_res
//
// - the front end takes one item per cycle while the 4-entry command queue
//   has room; unused action codes are dropped at the front
// - the back end emits one result per cycle into the output register while
//   it can take one; a transmit item yields up to three (header, byte, crc)
// - items that yield no result (hunting, idle abort) retire even while the
//   output register is stalled
// - reset clears the crc registers, frame state, queue and output valid
//
`default_nettype none

module camera_uart_frame_codec
  import cufc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // input items
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic [2:0] s_axis_tuser_i,   // [1:0] action, [2] first_of_frame
  input  wire logic       s_axis_tlast_i,   // last_of_frame
  // result items
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,   // [7:0] out_byte
  output logic [1:0]      m_axis_tuser_o,   // [1:0] kind
  output logic            m_axis_tlast_o    // final_res
);

  logic  push;
  cmd_t  push_cmd;
  logic  q_full;
  logic  pop;
  head_t head;

  // decode: action select into a queue command
  cufc_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .q_full_i        (q_full),
    .push_o          (push),
    .cmd_o           (push_cmd)
  );

  // decouples intake from result delivery
  cufc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .full_o (q_full),
    .head_o (head)
  );

  // framing, crc tracking and result register
  cufc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

### verif/frame_codec_checker.sv
// ----------------------------------------------------------------------------
// frame_codec_checker
// watches both item channels of the camera uart frame codec, works out the
// line bytes, payload bytes and frame verdicts that each accepted input item
// must cause, and compares every result item field by field in order
// ----------------------------------------------------------------------------

module frame_codec_checker
  import cufc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  // input channel
  input  logic       s_tvalid_i,
  input  logic       s_tready_i,
  input  logic [7:0] s_tdata_i,      // [7:0] data_byte
  input  logic [2:0] s_tuser_i,      // [1:0] action, [2] first_of_frame
  input  logic       s_tlast_i,      // last_of_frame
  // result channel
  input  logic       m_tvalid_i,
  input  logic       m_tready_i,
  input  logic [7:0] m_tdata_i,      // [7:0] out_byte
  input  logic [1:0] m_tuser_i,      // [1:0] kind
  input  logic       m_tlast_i,      // final_res
  output int         error_count_o,
  output int         outstanding_o
);

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       final_res;
  } result_t;

  result_t    expected_results[$];
  logic [7:0] tx_crc;
  logic [7:0] rx_crc;
  logic       rx_in_frame;

  // crc-8 dvb-s2, msb first, one byte folded in
  function automatic logic [7:0] crc_after(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    error_count_o++;
  endtask

  // results that one input item causes, appended to the expected results
  task automatic predict_results(input logic [1:0] action, input logic [7:0] b,
                                 input logic first, input logic last);
    result_t res [3];
    int      n;
    n = 0;
    case (action)
      ActTx: begin
        if (first) begin
          tx_crc = crc_after(8'h00, HdrByte);
          res[n] = '{KindTx, HdrByte, 1'b0};
          n++;
        end
        tx_crc = crc_after(tx_crc, b);
        res[n] = '{KindTx, b, 1'b0};
        n++;
        if (last) begin
          res[n] = '{KindTx, tx_crc, 1'b0};
          n++;
        end
      end
      ActRx: begin
        if (!rx_in_frame) begin
          // hunting: only the header opens a frame, nothing comes out
          if (b == HdrByte) begin
            rx_crc      = crc_after(8'h00, HdrByte);
            rx_in_frame = 1'b1;
          end
        end else if (b == rx_crc) begin
          res[n] = '{KindGood, 8'h00, 1'b0};
          n++;
          rx_in_frame = 1'b0;
          rx_crc      = 8'h00;
        end else begin
          rx_crc = crc_after(rx_crc, b);
          res[n] = '{KindPayload, b, 1'b0};
          n++;
        end
      end
      ActAbort: begin
        if (rx_in_frame) begin
          res[n] = '{KindBad, 8'h00, 1'b0};
          n++;
          rx_in_frame = 1'b0;
          rx_crc      = 8'h00;
        end
      end
      default: ;
    endcase
    if (n != 0) res[n - 1].final_res = 1'b1;
    for (int i = 0; i < n; i++) begin
      expected_results.insert(expected_results.size(), res[i]);
    end
  endtask

  task automatic check_result(input logic [1:0] kind, input logic [7:0] data,
                              input logic final_res);
    result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result kind %0d byte %02h last %0b",
                                kind, data, final_res));
    end else begin
      want = expected_results.pop_front();
      if (kind !== want.kind)
        report_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
      if (data !== want.data)
        report_mismatch($sformatf("byte %02h, want %02h (kind %0d)", data, want.data,
                                  want.kind));
      if (final_res !== want.final_res)
        report_mismatch($sformatf("final flag %0b, want %0b (kind %0d byte %02h)",
                                  final_res, want.final_res, want.kind, want.data));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_results.delete();
      tx_crc        = 8'h00;
      rx_crc        = 8'h00;
      rx_in_frame   = 1'b0;
      error_count_o = 0;
      outstanding_o = 0;
    end else begin
      // a result never comes from the item accepted at the same edge
      if (m_tvalid_i && m_tready_i) check_result(m_tuser_i, m_tdata_i, m_tlast_i);
      if (s_tvalid_i && s_tready_i)
        predict_results(s_tuser_i[1:0], s_tdata_i, s_tuser_i[2], s_tlast_i);
      outstanding_o = expected_results.size();
    end
  end

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the camera uart frame codec: a directed opening
// on the framing corner cases, then random transmit frames, receive frames
// with good, aborted and corrupted endings, and noise, with random gaps on
// the input side and random stalls on the result side
// ----------------------------------------------------------------------------

module tb;
  import cufc_pkg::*;

  localparam int         NumItems   = 470;
  localparam int         IdleLimit  = 2000;  // cycles without any accepted item
  localparam int         TailCycles = 40;    // settle time once nothing is expected
  localparam logic [1:0] ActUnused  = 2'd3;  // action code the block ignores

  typedef enum int {
    END_GOOD,
    END_ABORT,
    END_CORRUPT
  } frame_end_e;

  logic       clk_i    = 1'b0;
  logic       rst_ni   = 1'b0;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = 8'h00;
  logic [2:0] s_tuser  = 3'b000;
  logic       s_tlast  = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [1:0] m_tuser;
  logic       m_tlast;

  int   errors;
  int   outstanding;
  int   sent        = 0;
  int   idle_cycles = 0;
  logic calm        = 1'b0;  // when set neither side idles

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  camera_uart_frame_codec u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  frame_codec_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tvalid_i    (s_tvalid),
    .s_tready_i    (s_tready),
    .s_tdata_i     (s_tdata),
    .s_tuser_i     (s_tuser),
    .s_tlast_i     (s_tlast),
    .m_tvalid_i    (m_tvalid),
    .m_tready_i    (m_tready),
    .m_tdata_i     (m_tdata),
    .m_tuser_i     (m_tuser),
    .m_tlast_i     (m_tlast),
    .error_count_o (errors),
    .outstanding_o (outstanding)
  );

  // watchdog: a healthy run never goes long without a handshake
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // crc of the stimulus side, used only to build well-formed receive frames
  function automatic logic [7:0] dvb_crc_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

  // byte values biased toward the header and the extremes
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0:       return HdrByte;
      1:       return 8'h00;
      2:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // one input item, with a random gap before it unless calm
  task automatic send_item(input logic [1:0] action, input logic [7:0] b,
                           input logic first, input logic last);
    int gap;
    gap = calm ? 0 : $urandom_range(12);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= {first, action};
    s_tlast  <= last;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    sent++;
    // switch now and then into a stretch with no idling on either side
    if (sent % 32 == 0) calm = ($urandom_range(3) == 0);
  endtask

  // command, parameters, crc appended by the block on the last byte
  task automatic send_tx_frame(input int len);
    for (int i = 0; i < len; i++) begin
      send_item(ActTx, pick_byte(), i == 0, i == len - 1);
    end
  endtask

  // header, payload starting with lead, then the chosen ending; first and
  // last flags carry noise since receive items ignore them
  task automatic send_rx_frame(input int len, input frame_end_e ending,
                               input logic [7:0] lead);
    logic [7:0] run;
    logic [7:0] b;
    send_item(ActRx, HdrByte, 1'($urandom_range(1)), 1'($urandom_range(1)));
    run = dvb_crc_next(8'h00, HdrByte);
    for (int i = 0; i < len; i++) begin
      b = (i == 0) ? lead : pick_byte();
      if (b == run) b = ~b;  // keep the frame open
      send_item(ActRx, b, 1'($urandom_range(1)), 1'($urandom_range(1)));
      run = dvb_crc_next(run, b);
    end
    case (ending)
      END_GOOD: send_item(ActRx, run, 1'($urandom_range(1)), 1'($urandom_range(1)));
      END_ABORT: send_item(ActAbort, pick_byte(), 1'($urandom_range(1)),
                           1'($urandom_range(1)));
      default: begin
        // wrong crc goes through as payload, then the line idles out
        send_item(ActRx, run ^ 8'(1 << $urandom_range(7)), 1'b0, 1'b0);
        send_item(ActAbort, 8'h00, 1'b0, 1'b0);
      end
    endcase
  endtask

  // result side: random stall before each result, none while calm
  initial begin : result_sink
    int stall;
    wait (rst_ni);
    forever begin
      stall = calm ? 0 : $urandom_range(12);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_tvalid) @(posedge clk_i);
    end
  end

  initial begin : stimulus
    int pick;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed opening
    send_item(ActAbort, 8'hFF, 1'b1, 1'b1);   // abort while hunting is dropped
    send_item(ActRx, 8'h00, 1'b0, 1'b0);      // non-header byte while hunting
    send_item(ActUnused, 8'hFF, 1'b1, 1'b1);  // unused action code
    send_item(ActTx, 8'h00, 1'b1, 1'b1);      // header, byte and crc from one item
    send_item(ActTx, 8'hFF, 1'b1, 1'b0);
    send_item(ActTx, 8'h55, 1'b0, 1'b0);
    send_item(ActTx, 8'hAA, 1'b0, 1'b1);
    send_item(ActTx, 8'h12, 1'b0, 1'b1);      // no first: crc runs on unchanged
    send_item(ActTx, HdrByte, 1'b0, 1'b0);
    send_rx_frame(0, END_GOOD, 8'h00);        // crc right after the header
    send_rx_frame(3, END_GOOD, HdrByte);      // header value inside a frame
    send_rx_frame(2, END_ABORT, 8'hFF);
    send_rx_frame(1, END_CORRUPT, 8'h00);
    send_item(ActAbort, 8'h00, 1'b0, 1'b0);

    // random mix, mostly well-formed frames
    while (sent < NumItems) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        send_tx_frame($urandom_range(1, 6));
      end else if (pick < 70) begin
        pick = $urandom_range(99);
        send_rx_frame($urandom_range(0, 5),
                      (pick < 70) ? END_GOOD : (pick < 85) ? END_ABORT : END_CORRUPT,
                      pick_byte());
      end else if (pick < 80) begin
        send_item(ActTx, pick_byte(), 1'($urandom_range(1)), 1'($urandom_range(1)));
      end else if (pick < 90) begin
        send_item(ActRx, pick_byte(), 1'($urandom_range(1)), 1'($urandom_range(1)));
      end else if (pick < 96) begin
        send_item(ActAbort, pick_byte(), 1'($urandom_range(1)), 1'($urandom_range(1)));
      end else begin
        send_item(ActUnused, pick_byte(), 1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    end
    s_tvalid <= 1'b0;

    // drain, then give trailing no-result items time to retire
    @(negedge clk_i);
    while (outstanding != 0) @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
